### design/pfls_pkg.sv
// ----------------------------------------------------------------------------
// pfls_pkg
// Shared types and codes of the priority flow link scheduler.
// ----------------------------------------------------------------------------
package pfls_pkg;

   // event kinds
   localparam logic FUNC_ARRIVE = 1'b0;
   localparam logic FUNC_FINISH = 1'b1;

   typedef struct packed {
      logic        func;
      logic [7:0]  flow_id;
      logic [7:0]  priority_req;
      logic [15:0] arrival_time;
      logic [15:0] duration;
   } req_type;

   typedef struct packed {
      logic        granted;
      logic [7:0]  granted_flow;
      logic [15:0] granted_duration;
      logic        dropped;
      logic [4:0]  waiting_count;
   } rsp_type;

   // ordering key: a plain unsigned compare of the packed word gives
   // priority, then arrival, then duration, then flow id
   typedef struct packed {
      logic [7:0]  prio;
      logic [15:0] arrival;
      logic [15:0] duration;
      logic [7:0]  flow;
   } key_type;

endpackage

### design/priority_flow_link_scheduler.sv
// ----------------------------------------------------------------------------
// priority_flow_link_scheduler
// Non-preemptive priority scheduler for one shared link.
// ----------------------------------------------------------------------------
// Each request beat is an event: a flow arrival (stored in the lowest free
// slot, or dropped and flagged when all QUEUE_DEPTH slots are taken) or a
// link-finished notice. After every event, if the link is idle and flows
// wait, the best flow is granted: smallest priority number, then earliest
// arrival, then shortest duration, then smallest id, lowest slot on a full
// tie. Every event produces exactly one response beat. An event that grants
// nothing goes straight to the post state, which loads the response
// register; an event that grants first runs a sweep in the scan state that
// reads the slot RAM one entry per cycle through its single read port, then
// the post state. A still-stalled previous response beat holds the post
// state until the output register is free or being emptied. A new request
// is taken as soon as the previous response has been loaded into the
// output register, even while that beat is still stalled downstream. Slot
// contents live in the RAM; only the valid bits, occupancy, link state and
// the state machine and sweep and handshake control flags are flops cleared
// by reset, so no clearing pass is needed.
// ----------------------------------------------------------------------------
module priority_flow_link_scheduler
   import pfls_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int OCC_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(QUEUE_DEPTH - 1);

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_SCAN = 2'd1;
   localparam logic [1:0] ST_POST = 2'd2;

   logic [1:0]             state_ff, state_in;
   logic [QUEUE_DEPTH-1:0] valid_ff, valid_in;
   logic [OCC_W-1:0]       occ_ff, occ_in;
   logic                   busy_ff, busy_in;

   // sweep control
   logic [IDX_W-1:0]       scan_idx_ff, scan_idx_in;
   logic                   issued_ff, issued_in;
   logic                   cmp_vld_ff, cmp_vld_in;
   logic [IDX_W-1:0]       cmp_idx_ff, cmp_idx_in;
   logic                   found_ff, found_in;
   logic [IDX_W-1:0]       best_idx_ff, best_idx_in;
   key_type                best_key_ff, best_key_in;

   // result staging and output register
   rsp_type                res_ff, res_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   rsp_type                rsp_data_ff, rsp_data_in;

   // slot RAM ports
   logic                   wr_en;
   logic [IDX_W-1:0]       wr_addr;
   key_type                wr_key;
   key_type                rd_key;

   // lowest free slot
   logic                   free_any;
   logic [IDX_W-1:0]       free_idx;

   logic                   take;
   logic [IDX_W-1:0]       win_idx;
   key_type                win_key;
   logic [OCC_W-1:0]       occ_after;
   logic                   busy_after;

   pfls_slot_ram #(
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_key  (wr_key),
      .rd_addr (scan_idx_ff),
      .rd_key  (rd_key)
   );

   always_comb begin
      free_any = 1'b0;
      free_idx = '0;
      for (int i = QUEUE_DEPTH - 1; i >= 0; i--) begin
         if (!valid_ff[i]) begin
            free_any = 1'b1;
            free_idx = IDX_W'(i);
         end
      end
   end

   // compare stage: candidate from the RAM against the best so far
   assign take    = cmp_vld_ff && valid_ff[cmp_idx_ff] &&
                    (!found_ff || (rd_key < best_key_ff));
   assign win_idx = take ? cmp_idx_ff : best_idx_ff;
   assign win_key = take ? rd_key : best_key_ff;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   always_comb begin
      state_in     = state_ff;
      valid_in     = valid_ff;
      occ_in       = occ_ff;
      busy_in      = busy_ff;
      scan_idx_in  = scan_idx_ff;
      issued_in    = issued_ff;
      cmp_vld_in   = 1'b0;
      cmp_idx_in   = scan_idx_ff;
      found_in     = found_ff;
      best_idx_in  = best_idx_ff;
      best_key_in  = best_key_ff;
      res_in       = res_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      wr_en        = 1'b0;
      wr_addr      = free_idx;
      wr_key       = '{prio:     req_data.priority_req,
                       arrival:  req_data.arrival_time,
                       duration: req_data.duration,
                       flow:     req_data.flow_id};
      occ_after    = occ_ff;
      busy_after   = busy_ff;

      // drop the output beat once taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               res_in = '0;
               if (req_data.func == FUNC_ARRIVE) begin
                  if (free_any) begin
                     wr_en              = 1'b1;
                     valid_in[free_idx] = 1'b1;
                     occ_after          = occ_ff + OCC_W'(1);
                  end else begin
                     res_in.dropped = 1'b1;
                  end
               end else begin
                  busy_after = 1'b0;
               end
               occ_in  = occ_after;
               busy_in = busy_after;
               if (!busy_after && (occ_after != '0)) begin
                  // start a sweep over the table
                  state_in    = ST_SCAN;
                  scan_idx_in = '0;
                  issued_in   = 1'b0;
                  found_in    = 1'b0;
               end else begin
                  res_in.waiting_count = 5'(occ_after);
                  state_in             = ST_POST;
               end
            end
         end

         ST_SCAN: begin
            // issue one read per cycle
            if (!issued_ff) begin
               cmp_vld_in = 1'b1;
               cmp_idx_in = scan_idx_ff;
               if (scan_idx_ff == LAST_IDX) begin
                  issued_in = 1'b1;
               end else begin
                  scan_idx_in = scan_idx_ff + IDX_W'(1);
               end
            end
            if (take) begin
               found_in    = 1'b1;
               best_idx_in = cmp_idx_ff;
               best_key_in = rd_key;
            end
            // last compare: grant the winner
            if (cmp_vld_ff && (cmp_idx_ff == LAST_IDX)) begin
               valid_in[win_idx]       = 1'b0;
               occ_in                  = occ_ff - OCC_W'(1);
               busy_in                 = 1'b1;
               res_in.granted          = 1'b1;
               res_in.granted_flow     = win_key.flow;
               res_in.granted_duration = win_key.duration;
               res_in.waiting_count    = 5'(occ_ff - OCC_W'(1));
               state_in                = ST_POST;
            end
         end

         ST_POST: begin
            // load the output register when it is free or being emptied
            if (!rsp_valid_ff || !rsp_stall) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = res_ff;
               state_in     = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         valid_ff     <= '0;
         occ_ff       <= '0;
         busy_ff      <= 1'b0;
         issued_ff    <= 1'b0;
         cmp_vld_ff   <= 1'b0;
         found_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         valid_ff     <= valid_in;
         occ_ff       <= occ_in;
         busy_ff      <= busy_in;
         issued_ff    <= issued_in;
         cmp_vld_ff   <= cmp_vld_in;
         found_ff     <= found_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      scan_idx_ff <= scan_idx_in;
      cmp_idx_ff  <= cmp_idx_in;
      best_idx_ff <= best_idx_in;
      best_key_ff <= best_key_in;
      res_ff      <= res_in;
      rsp_data_ff <= rsp_data_in;
   end

endmodule

### design/pfls_slot_ram.sv
// ----------------------------------------------------------------------------
// pfls_slot_ram
// Slot table storage: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module pfls_slot_ram
   import pfls_pkg::*;
#(
   parameter int DEPTH = 16
) (
   input  logic                                 clock,
   input  logic                                 wr_en,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
   input  key_type                              wr_key,
   input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
   output key_type                              rd_key
);

   key_type mem [DEPTH];
   key_type rd_key_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_key;
      end
      rd_key_ff <= mem[rd_addr];
   end

   assign rd_key = rd_key_ff;

endmodule

### design/pfls_checker.sv
// ----------------------------------------------------------------------------
// pfls_checker
// Port-level checks of the priority flow link scheduler, bound to the top.
// ----------------------------------------------------------------------------
module pfls_checker
   import pfls_pkg::*;
#(
   parameter int QUEUE_DEPTH = 16
) (
   input logic    clock,
   input logic    reset,
   input logic    req_valid,
   input logic    req_stall,
   input logic    rsp_valid,
   input logic    rsp_stall,
   input rsp_type rsp_data
);

   // a stalled response beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("response beat changed while stalled");

   // an accepted event stalls the request side in the next cycle
   a_req_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> req_stall)
      else $error("request taken while the previous event was in flight");

   // a beat without a grant carries an empty flow id and duration
   a_no_grant_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.granted |->
         rsp_data.granted_flow == 8'd0 && rsp_data.granted_duration == 16'd0)
      else $error("grant fields set without a grant");

   // a drop only happens on a full table behind a busy link
   a_drop_full: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.dropped |->
         !rsp_data.granted && rsp_data.waiting_count == 5'(QUEUE_DEPTH))
      else $error("drop without a full table");

   // waiting count never exceeds the table
   a_count_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> 32'(rsp_data.waiting_count) <= QUEUE_DEPTH)
      else $error("waiting count beyond table depth");

endmodule

bind priority_flow_link_scheduler pfls_checker #(
   .QUEUE_DEPTH (QUEUE_DEPTH)
) u_pfls_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_valid),
   .req_stall (req_stall),
   .rsp_valid (rsp_valid),
   .rsp_stall (rsp_stall),
   .rsp_data  (rsp_data)
);

### tb/priority_flow_link_scheduler_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// priority_flow_link_scheduler_tb
// Self-checking bench for the non-preemptive link scheduler. A scoreboard
// mirrors the flow table and link state, predicts one response beat per
// accepted event, and compares every returned beat field by field. A short
// directed sequence covers the ordering keys, ties, a full table and
// finish events, then several hundred random events follow. Both
// channels idle at random, and the response side holds off for a while.
// ----------------------------------------------------------------------------
module priority_flow_link_scheduler_tb;
   import pfls_pkg::*;

   localparam int DEPTH       = 16;
   localparam int RAND_BEATS  = 530;
   localparam int HOLD_CYCLES = 200;
   localparam int DRAIN_WAIT  = 2 * DEPTH + 16;
   localparam int CYCLE_CAP   = 200000;

   // -------------------------------------------------------------------------
   // Scoreboard: mirror of the flow table and link, plus the queue of
   // responses still owed by the block.
   // -------------------------------------------------------------------------
   class grant_scoreboard;
      req_type flow_tab[DEPTH];
      bit      slot_used[DEPTH];
      bit      link_held;
      int      waiting;
      rsp_type owed_rsp[$];
      int      mismatches;
      int      events;
      int      grants;
      int      drops;
      int      idle_finishes;
      int      rsp_checked;

      function new();
         int i;
         for (i = 0; i < DEPTH; i++) slot_used[i] = 1'b0;
         link_held     = 1'b0;
         waiting       = 0;
         mismatches    = 0;
         events        = 0;
         grants        = 0;
         drops         = 0;
         idle_finishes = 0;
         rsp_checked   = 0;
      endfunction

      // true when flow a should be served strictly before flow b
      function bit outranks(input req_type a, input req_type b);
         if (a.priority_req != b.priority_req) return a.priority_req < b.priority_req;
         if (a.arrival_time != b.arrival_time) return a.arrival_time < b.arrival_time;
         if (a.duration != b.duration) return a.duration < b.duration;
         return a.flow_id < b.flow_id;
      endfunction

      // advance the mirror by one accepted event and queue the response
      function void note_event(input req_type ev);
         rsp_type exp;
         int      i;
         int      best;
         bit      placed;
         exp    = '0;
         best   = -1;
         placed = 1'b0;
         events++;
         if (ev.func == FUNC_ARRIVE) begin
            for (i = 0; i < DEPTH && !placed; i++) begin
               if (!slot_used[i]) begin
                  slot_used[i] = 1'b1;
                  flow_tab[i]  = ev;
                  waiting++;
                  placed = 1'b1;
               end
            end
            if (!placed) begin
               exp.dropped = 1'b1;
               drops++;
            end
         end else begin
            if (!link_held) idle_finishes++;
            link_held = 1'b0;
         end
         if (!link_held) begin
            // lowest slot wins a full tie, since only a strict win replaces
            for (i = 0; i < DEPTH; i++) begin
               if (slot_used[i] && (best < 0 || outranks(flow_tab[i], flow_tab[best])))
                  best = i;
            end
            if (best >= 0) begin
               exp.granted          = 1'b1;
               exp.granted_flow     = flow_tab[best].flow_id;
               exp.granted_duration = flow_tab[best].duration;
               slot_used[best]      = 1'b0;
               waiting--;
               link_held = 1'b1;
               grants++;
            end
         end
         exp.waiting_count = 5'(waiting);
         owed_rsp.push_back(exp);
      endfunction

      function void flag(input string what);
         mismatches++;
         if (mismatches <= 10) $display("[%0t] MISMATCH %s", $time, what);
      endfunction

      // compare one returned beat against the oldest owed response
      function void check_result(input rsp_type got);
         rsp_type exp;
         bit      bad;
         rsp_checked++;
         if (owed_rsp.size() == 0) begin
            flag($sformatf("unexpected response beat %p", got));
            return;
         end
         exp = owed_rsp.pop_front();
         bad = (got.granted !== exp.granted)
            || (got.granted_flow !== exp.granted_flow)
            || (got.granted_duration !== exp.granted_duration)
            || (got.dropped !== exp.dropped)
            || (got.waiting_count !== exp.waiting_count);
         if (bad)
            flag($sformatf("beat %0d: expected %p, got %p", rsp_checked, exp, got));
      endfunction

      function int pending();
         return owed_rsp.size();
      endfunction
   endclass

   // -------------------------------------------------------------------------
   // Signals and DUT
   // -------------------------------------------------------------------------
   logic    clock;
   logic    reset     = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data  = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   grant_scoreboard sb = new();
   int   in_count  = 0;     // accepted request beats, updated at the edge
   int   hold_left = 0;
   bit   hold_done = 1'b0;
   logic quiet;

   // stretch of the run with no idling on either side
   assign quiet = (in_count >= 330) && (in_count < 450);

   priority_flow_link_scheduler #(
      .QUEUE_DEPTH(DEPTH)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   // -------------------------------------------------------------------------
   // Monitor: sample both channels on the edge, before any driver update
   // lands, so a beat is seen exactly when the handshake completes.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (!reset) begin
         if (req_valid && !req_stall) begin
            sb.note_event(req_data);
            in_count <= in_count + 1;
         end
         if (rsp_valid && !rsp_stall) sb.check_result(rsp_data);
      end
   end

   // -------------------------------------------------------------------------
   // Response side: stall at random, except in the quiet stretch. Once,
   // hold off for a long stretch so the block backs up and stalls requests.
   // -------------------------------------------------------------------------
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (!hold_done && in_count >= 120) begin
         hold_done <= 1'b1;
         hold_left <= HOLD_CYCLES - 1;
         rsp_stall <= 1'b1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 12);
      end
   end

   // -------------------------------------------------------------------------
   // Request side
   // -------------------------------------------------------------------------

   // offer one beat, idling first now and then; return on acceptance
   task automatic send_beat(input req_type beat);
      if (!quiet && $urandom_range(99) < 12) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(4, 1)) @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= beat;
      @(posedge clock);
      while (req_stall) @(posedge clock);
   endtask

   // drop valid and hold until every owed response has come back
   task automatic wait_drained();
      req_valid <= 1'b0;
      do @(negedge clock); while (sb.pending() != 0);
      @(posedge clock);
   endtask

   function automatic req_type arrival(input logic [7:0] id, input logic [7:0] prio,
                                       input logic [15:0] at, input logic [15:0] dur);
      req_type ev;
      ev.func         = FUNC_ARRIVE;
      ev.flow_id      = id;
      ev.priority_req = prio;
      ev.arrival_time = at;
      ev.duration     = dur;
      return ev;
   endfunction

   // random event; narrow key ranges (priority half the time, arrival and duration a third) to force ties
   function automatic req_type random_event(input int arrive_pct);
      req_type ev;
      ev = req_type'($bits(req_type)'({$urandom, $urandom}));
      if ($urandom_range(99) < arrive_pct) begin
         ev.func = FUNC_ARRIVE;
         if ($urandom_range(1) == 0) ev.priority_req = 8'($urandom_range(3));
         if ($urandom_range(2) == 0) ev.arrival_time = 16'($urandom_range(7));
         if ($urandom_range(2) == 0) ev.duration = 16'($urandom_range(3));
      end else begin
         ev.func = FUNC_FINISH;
      end
      return ev;
   endfunction

   initial begin
      int k;
      int arrive_pct;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // finish on an idle link; every ignored field at its top value
      send_beat({FUNC_FINISH, 8'hFF, 8'hFF, 16'hFFFF, 16'hFFFF});
      // id zero with all keys at top: granted at once, link now busy
      send_beat(arrival(8'd0, 8'hFF, 16'hFFFF, 16'hFFFF));
      // fill all sixteen slots while the link is held
      send_beat(arrival(8'hFF, 8'd0, 16'd0, 16'd0));
      send_beat(arrival(8'd10, 8'd5, 16'd100, 16'd50));
      send_beat(arrival(8'd11, 8'd5, 16'd90, 16'd50));    // earlier arrival
      send_beat(arrival(8'd12, 8'd5, 16'd90, 16'd40));    // shorter duration
      send_beat(arrival(8'd9, 8'd5, 16'd90, 16'd40));     // smaller id
      send_beat(arrival(8'd9, 8'd5, 16'd90, 16'd40));     // tie on every key
      send_beat(arrival(8'd0, 8'd5, 16'd90, 16'd40));     // id zero has the smallest id of the tied flows
      for (k = 0; k < 9; k++)
         send_beat(arrival(8'(20 + k), 8'(k * 31), 16'(k * 7919), 16'(65535 - k * 1000)));
      // table full: this would be the best flow, but it must be dropped
      send_beat(arrival(8'hAA, 8'd0, 16'd0, 16'd0));
      // release the link a few times; each finish grants the next best
      for (k = 0; k < 4; k++)
         send_beat({FUNC_FINISH, 8'h00, 8'h00, 16'h0000, 16'h0000});

      // random part: cycle through fill, balanced and drain phases
      for (k = 0; k < RAND_BEATS; k++) begin
         case ((k / 60) % 3)
            0: arrive_pct = 80;
            1: arrive_pct = 50;
            default: arrive_pct = 25;
         endcase
         if (k == 300) wait_drained();
         send_beat(random_event(arrive_pct));
      end

      wait_drained();
      repeat (DRAIN_WAIT) @(posedge clock);

      $display("Ran %0d events: %0d grants, %0d drops on a full table, %0d idle finishes.",
               sb.events, sb.grants, sb.drops, sb.idle_finishes);
      $display("Checked %0d response beats, %0d mismatches, across one long response hold-off.",
               sb.rsp_checked, sb.mismatches);
      if (sb.mismatches == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

   // watchdog
   initial begin
      repeat (CYCLE_CAP) @(posedge clock);
      $display("DONE: errors detected");
      $finish;
   end

endmodule
